[src/qsed_pkg.sv]
// Shared types and codes for the quoted string escape decoder.
// Used by the front end, queue, back end, top level and testbench.
package qsed_pkg;

    localparam int unsigned MaxResults = 3;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_QUOTE = 2'd1,
        ST_DANGLING = 2'd2,
        ST_TRAILING = 2'd3
    } status_t;

    typedef struct packed {
        logic [7:0] byte_out;
        status_t    status;
        logic       string_done;
    } result_t;

    // All results of one input byte, first result in res[0].
    typedef struct packed {
        logic [1:0]                    cnt;
        result_t [MaxResults-1:0]      res;
    } bundle_t;

endpackage

[src/qsed_in_if.sv]
// Input channel: one raw string byte per word with a last-byte flag.
// Depends on nothing.
interface qsed_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       final_char;

    modport source (output valid, output char_in, output final_char, input ready);
    modport sink   (input valid, input char_in, input final_char, output ready);
endinterface

[src/qsed_out_if.sv]
// Output channel: one decoded byte per word with status and end flag.
// Depends on nothing.
interface qsed_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_out;
    logic [1:0] status;
    logic       string_done;

    modport source (output valid, output byte_out, output status, output string_done,
                    input ready);
    modport sink   (input valid, input byte_out, input status, input string_done,
                    output ready);
endinterface

[src/quoted_string_escape_decoder.sv]
// Quoted string escape decoder, top level.
// Channels: in_ch takes one raw byte of a double-quoted string per word,
// final_char marking its last byte; out_ch gives decoded bytes, each with
// status and string_done. Every string ends in exactly one word with
// string_done set: the terminator (closing quote or end of input) with
// status 0, or an error word (missing opening quote, dangling backslash,
// text after closing quote) after which the rest of the string is dropped.
// Throughput: one input byte per cycle while the queue has room. The back
// end sends one word per cycle while out_ch.ready allows, so a byte that
// yields two or three words (pending numeric escape, terminator) holds the
// output for each of its words; the queue of DEPTH bundles absorbs such bursts.
// Path: the edge that accepts a byte writes its bundle into the queue; a later
// edge loads its first word into the output register once no older word is ahead.
// Reset: rst_n clears the decode state, the queue and the output valid flag;
// the decoder then waits for an opening quote.
// Stall: with out_ch.ready low the output register holds its word, the
// queue fills, and in_ch.ready drops when the queue is full.
// Depends on qsed_pkg, qsed_in_if, qsed_out_if, qsed_front, qsed_fifo, qsed_back.
module quoted_string_escape_decoder #(
    parameter int unsigned DEPTH = 4
) (
    input  logic       clk,
    input  logic       rst_n,
    qsed_in_if.sink    in_ch,
    qsed_out_if.source out_ch
);
    import qsed_pkg::*;

    bundle_t bundle;
    bundle_t head;
    logic    has_results;
    logic    accept;
    logic    empty;
    logic    full;
    logic    pop;

    assign in_ch.ready = !full;
    assign accept      = in_ch.valid && !full;

    qsed_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .char_in     (in_ch.char_in),
        .final_char  (in_ch.final_char),
        .bundle      (bundle),
        .has_results (has_results)
    );

    qsed_fifo #(
        .DEPTH (DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept && has_results),
        .push_data (bundle),
        .pop       (pop),
        .head      (head),
        .empty     (empty),
        .full      (full)
    );

    qsed_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .empty  (empty),
        .pop    (pop),
        .out_ch (out_ch)
    );

endmodule

[src/qsed_front.sv]
// Front end: decode state machine, one input byte per cycle while accept is high, up to three results.
// Depends on qsed_pkg.
module qsed_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [7:0]        char_in,
    input  logic              final_char,
    output qsed_pkg::bundle_t bundle,
    output logic              has_results
);
    import qsed_pkg::*;

    typedef enum logic [2:0] {
        M_OPEN  = 3'd0,
        M_BODY  = 3'd1,
        M_ESC   = 3'd2,
        M_OCT   = 3'd3,
        M_HEX   = 3'd4,
        M_AFTER = 3'd5,
        M_DROP  = 3'd6
    } mode_t;

    localparam logic [7:0] ChBsl   = 8'h5C;
    localparam logic [7:0] ChQuote = 8'h22;
    localparam logic [7:0] ChX     = 8'h78;
    localparam logic [1:0] MaxDigits = 2'd3;

    mode_t      mode_reg, mode_next;
    logic [7:0] accum_reg, accum_next;
    logic [1:0] count_reg, count_next;

    logic       do_body;
    logic       do_finish;
    logic       digit_ok;
    logic [3:0] digit_val;
    logic [1:0] k;
    result_t [MaxResults-1:0] res;

    always_comb
    begin
        digit_ok  = 1'b0;
        digit_val = 4'd0;
        if (mode_reg == M_OCT)
        begin
            if (char_in inside {[8'h30:8'h37]})
            begin
                digit_ok  = 1'b1;
                digit_val = {1'b0, char_in[2:0]};
            end
        end
        else if (char_in inside {[8'h30:8'h39]})
        begin
            digit_ok  = 1'b1;
            digit_val = char_in[3:0];
        end
        else if (char_in inside {[8'h61:8'h66], [8'h41:8'h46]})
        begin
            digit_ok  = 1'b1;
            digit_val = char_in[3:0] + 4'd9;
        end
    end

    always_comb
    begin
        mode_next  = mode_reg;
        accum_next = accum_reg;
        count_next = count_reg;
        do_body    = 1'b0;
        do_finish  = 1'b0;
        k          = 2'd0;
        res        = '0;

        case (mode_reg)
            M_OPEN:
            begin
                if (char_in == ChQuote)
                begin
                    mode_next = M_BODY;
                    if (final_char)
                    begin
                        res[k] = '{8'd0, ST_OK, 1'b1};
                        k = k + 2'd1;
                    end
                end
                else
                begin
                    res[k] = '{8'd0, ST_NO_QUOTE, 1'b1};
                    k = k + 2'd1;
                    mode_next = M_DROP;
                end
            end
            M_BODY:
            begin
                do_body = 1'b1;
            end
            M_ESC:
            begin
                mode_next = M_BODY;
                do_finish = 1'b1;
                case (char_in)
                    8'h6E: begin res[k] = '{8'h0A, ST_OK, 1'b0}; k = k + 2'd1; end
                    8'h74: begin res[k] = '{8'h09, ST_OK, 1'b0}; k = k + 2'd1; end
                    8'h76: begin res[k] = '{8'h0B, ST_OK, 1'b0}; k = k + 2'd1; end
                    8'h62: begin res[k] = '{8'h08, ST_OK, 1'b0}; k = k + 2'd1; end
                    8'h72: begin res[k] = '{8'h0D, ST_OK, 1'b0}; k = k + 2'd1; end
                    8'h66: begin res[k] = '{8'h0C, ST_OK, 1'b0}; k = k + 2'd1; end
                    default:
                    begin
                        if (char_in inside {[8'h30:8'h37]})
                        begin
                            mode_next  = M_OCT;
                            accum_next = {5'd0, char_in[2:0]};
                            count_next = 2'd1;
                        end
                        else if (char_in == ChX)
                        begin
                            mode_next  = M_HEX;
                            accum_next = 8'd0;
                            count_next = 2'd0;
                        end
                        else
                        begin
                            res[k] = '{char_in, ST_OK, 1'b0};
                            k = k + 2'd1;
                        end
                    end
                endcase
            end
            M_OCT, M_HEX:
            begin
                if (digit_ok)
                begin
                    if (mode_reg == M_OCT)
                        accum_next = {accum_reg[4:0], digit_val[2:0]};
                    else
                        accum_next = {accum_reg[3:0], digit_val};
                    count_next = count_reg + 2'd1;
                    if (count_next >= MaxDigits)
                    begin
                        res[k] = '{accum_next, ST_OK, 1'b0};
                        k = k + 2'd1;
                        mode_next = M_BODY;
                    end
                    do_finish = 1'b1;
                end
                else
                begin
                    res[k] = '{accum_reg, ST_OK, 1'b0};
                    k = k + 2'd1;
                    do_body = 1'b1;
                end
            end
            M_AFTER:
            begin
                res[k] = '{8'd0, ST_TRAILING, 1'b1};
                k = k + 2'd1;
                mode_next = M_DROP;
            end
            default:
            begin
                mode_next = M_DROP;
            end
        endcase

        if (do_body)
        begin
            mode_next = M_BODY;
            if (char_in == ChBsl)
            begin
                if (final_char)
                begin
                    res[k] = '{8'd0, ST_DANGLING, 1'b1};
                    k = k + 2'd1;
                end
                else
                    mode_next = M_ESC;
            end
            else if (char_in == ChQuote)
            begin
                if (final_char)
                begin
                    res[k] = '{8'd0, ST_OK, 1'b1};
                    k = k + 2'd1;
                end
                else
                    mode_next = M_AFTER;
            end
            else
            begin
                res[k] = '{char_in, ST_OK, 1'b0};
                k = k + 2'd1;
                if (final_char)
                begin
                    res[k] = '{8'd0, ST_OK, 1'b1};
                    k = k + 2'd1;
                end
            end
        end

        // flush a pending numeric escape, then terminate
        if (do_finish && final_char)
        begin
            if (mode_next == M_OCT || mode_next == M_HEX)
            begin
                res[k] = '{accum_next, ST_OK, 1'b0};
                k = k + 2'd1;
            end
            res[k] = '{8'd0, ST_OK, 1'b1};
            k = k + 2'd1;
        end

        if (final_char)
        begin
            mode_next  = M_OPEN;
            accum_next = 8'd0;
            count_next = 2'd0;
        end
    end

    assign bundle.cnt  = k;
    assign bundle.res  = res;
    assign has_results = (k != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= M_OPEN;
            accum_reg <= 8'd0;
            count_reg <= 2'd0;
        end
        else if (accept)
        begin
            mode_reg  <= mode_next;
            accum_reg <= accum_next;
            count_reg <= count_next;
        end
    end

endmodule

[src/qsed_fifo.sv]
// Short queue of result bundles between front and back end.
// Depends on qsed_pkg.
module qsed_fifo #(
    parameter int unsigned DEPTH = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  qsed_pkg::bundle_t push_data,
    input  logic              pop,
    output qsed_pkg::bundle_t head,
    output logic              empty,
    output logic              full
);
    import qsed_pkg::*;

    localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

    bundle_t mem [DEPTH];

    logic [PtrW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CntW-1:0] cnt_reg;

    assign empty = (cnt_reg == '0);
    assign full  = (cnt_reg == FullCnt);
    assign head  = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

[src/qsed_back.sv]
// Back end: walks each queued bundle and presents one result per word
// from an output register. Depends on qsed_pkg and qsed_out_if.
module qsed_back (
    input  logic              clk,
    input  logic              rst_n,
    input  qsed_pkg::bundle_t head,
    input  logic              empty,
    output logic              pop,
    qsed_out_if.source        out_ch
);
    import qsed_pkg::*;

    logic       out_valid_reg;
    result_t    out_res_reg;
    logic [1:0] idx_reg;
    logic       load;
    logic       last;

    assign load = !out_valid_reg || out_ch.ready;
    assign last = (idx_reg == head.cnt - 2'd1);
    assign pop  = load && !empty && last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
        end
        else if (load)
        begin
            out_valid_reg <= !empty;
            if (!empty)
                idx_reg <= last ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && !empty)
            out_res_reg <= head.res[idx_reg];
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.byte_out    = out_res_reg.byte_out;
    assign out_ch.status      = out_res_reg.status;
    assign out_ch.string_done = out_res_reg.string_done;

endmodule

[tb/testbench.sv]
// Self-checking testbench for quoted_string_escape_decoder.
// Drives quoted strings through qsed_in_if and checks every decoded word on qsed_out_if
// against a behavioral predictor; depends on qsed_pkg, the two channel interfaces and the decoder.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import qsed_pkg::*;

    localparam int unsigned RANDOM_ITEMS   = 200;
    localparam int unsigned RX_HOLD_CYCLES = 150;
    localparam int unsigned DRAIN_CYCLES   = 20;
    localparam int unsigned CYCLE_LIMIT    = 100000;
    localparam int unsigned MAX_DIGITS     = 3;

    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_X     = "x";
    localparam logic [7:0] CH_N     = "n";
    localparam logic [7:0] CH_T     = "t";
    localparam logic [7:0] CH_V     = "v";
    localparam logic [7:0] CH_B     = "b";
    localparam logic [7:0] CH_R     = "r";
    localparam logic [7:0] CH_F     = "f";
    localparam logic [7:0] CH_0     = "0";
    localparam logic [7:0] CH_7     = "7";
    localparam logic [7:0] CH_9     = "9";
    localparam logic [7:0] CH_LA    = "a";
    localparam logic [7:0] CH_LF    = "f";
    localparam logic [7:0] CH_UA    = "A";
    localparam logic [7:0] CH_UF    = "F";

    typedef enum logic [2:0] {
        PS_OPEN,
        PS_BODY,
        PS_ESC,
        PS_OCT,
        PS_HEX,
        PS_AFTER,
        PS_DROP
    } parse_state_t;

    class escape_scoreboard;
        parse_state_t state;
        logic [7:0]   accum;
        logic [1:0]   ndigits;
        result_t      expected_q[$];
        int unsigned  errors;

        function new();
            errors = 0;
            clear_state();
        endfunction

        function void clear_state();
            state   = PS_OPEN;
            accum   = 8'h00;
            ndigits = 2'd0;
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        function void push(logic [7:0] b, status_t st, logic done);
            result_t r;
            r.byte_out    = b;
            r.status      = st;
            r.string_done = done;
            expected_q.push_back(r);
        endfunction

        function int digit_value(logic [7:0] c, bit octal);
            if (c >= CH_0 && c <= CH_7)
                return c - CH_0;
            if (octal)
                return -1;
            if (c >= CH_0 && c <= CH_9)
                return c - CH_0;
            if (c >= CH_LA && c <= CH_LF)
                return c - CH_LA + 10;
            if (c >= CH_UA && c <= CH_UF)
                return c - CH_UA + 10;
            return -1;
        endfunction

        function void plain_byte(logic [7:0] c, logic fin);
            state = PS_BODY;
            if (c == CH_BSL)
            begin
                if (fin)
                    push(8'h00, ST_DANGLING, 1'b1);
                else
                    state = PS_ESC;
            end
            else if (c == CH_QUOTE)
            begin
                if (fin)
                    push(8'h00, ST_OK, 1'b1);
                else
                    state = PS_AFTER;
            end
            else
            begin
                push(c, ST_OK, 1'b0);
                if (fin)
                    push(8'h00, ST_OK, 1'b1);
            end
        endfunction

        // On the last byte, flush a pending numeric escape, then terminate.
        function void close_string(logic fin);
            if (!fin)
                return;
            if (state == PS_OCT || state == PS_HEX)
                push(accum, ST_OK, 1'b0);
            push(8'h00, ST_OK, 1'b1);
        endfunction

        // Returns 0 when the byte is dropped after an error.
        function bit note_input(logic [7:0] c, logic fin);
            int dv;
            bit used;
            used = 1'b1;
            case (state)
                PS_OPEN:
                begin
                    if (c == CH_QUOTE)
                    begin
                        state = PS_BODY;
                        if (fin)
                            push(8'h00, ST_OK, 1'b1);
                    end
                    else
                    begin
                        push(8'h00, ST_NO_QUOTE, 1'b1);
                        state = PS_DROP;
                    end
                end
                PS_BODY:
                    plain_byte(c, fin);
                PS_ESC:
                begin
                    state = PS_BODY;
                    case (c)
                        CH_N: push(8'h0A, ST_OK, 1'b0);
                        CH_T: push(8'h09, ST_OK, 1'b0);
                        CH_V: push(8'h0B, ST_OK, 1'b0);
                        CH_B: push(8'h08, ST_OK, 1'b0);
                        CH_R: push(8'h0D, ST_OK, 1'b0);
                        CH_F: push(8'h0C, ST_OK, 1'b0);
                        default:
                        begin
                            if (c >= CH_0 && c <= CH_7)
                            begin
                                state   = PS_OCT;
                                accum   = c - CH_0;
                                ndigits = 2'd1;
                            end
                            else if (c == CH_X)
                            begin
                                state   = PS_HEX;
                                accum   = 8'h00;
                                ndigits = 2'd0;
                            end
                            else
                                push(c, ST_OK, 1'b0);
                        end
                    endcase
                    close_string(fin);
                end
                PS_OCT, PS_HEX:
                begin
                    dv = digit_value(c, state == PS_OCT);
                    if (dv >= 0)
                    begin
                        if (state == PS_OCT)
                            accum = {accum[4:0], 3'b000} + 8'(dv);
                        else
                            accum = {accum[3:0], 4'b0000} + 8'(dv);
                        ndigits = ndigits + 2'd1;
                        if (ndigits >= MAX_DIGITS)
                        begin
                            push(accum, ST_OK, 1'b0);
                            state = PS_BODY;
                        end
                        close_string(fin);
                    end
                    else
                    begin
                        // emit the accumulated byte, then decode this one as ordinary text
                        push(accum, ST_OK, 1'b0);
                        plain_byte(c, fin);
                    end
                end
                PS_AFTER:
                begin
                    push(8'h00, ST_TRAILING, 1'b1);
                    state = PS_DROP;
                end
                default:
                begin
                    state = PS_DROP;
                    used  = 1'b0;
                end
            endcase
            if (fin)
                clear_state();
            return used;
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected word byte_out=%h status=%0d string_done=%b",
                         $time, got.byte_out, got.status, got.string_done);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (got.byte_out !== want.byte_out)
            begin
                $display("%0t: byte_out expected %h actual %h",
                         $time, want.byte_out, got.byte_out);
                errors++;
            end
            if (got.status !== want.status)
            begin
                $display("%0t: status expected %0d actual %0d",
                         $time, want.status, got.status);
                errors++;
            end
            if (got.string_done !== want.string_done)
            begin
                $display("%0t: string_done expected %b actual %b",
                         $time, want.string_done, got.string_done);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    qsed_in_if  in_ch();
    qsed_out_if out_ch();

    quoted_string_escape_decoder uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    escape_scoreboard sb = new();

    logic [7:0]  text_q[$];
    bit          calm;
    bit          stall_req;
    int unsigned live_items;
    int unsigned cycles;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles >= CYCLE_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // Output side: check accepted words, stall at random or for a long hold-off.
    initial
    begin : word_sink
        int      hold_left;
        result_t got;
        hold_left    = 0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_ch.valid && out_ch.ready)
            begin
                got.byte_out    = out_ch.byte_out;
                got.status      = status_t'(out_ch.status);
                got.string_done = out_ch.string_done;
                sb.check_result(got);
            end
            if (stall_req)
            begin
                hold_left = RX_HOLD_CYCLES;
                stall_req = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= calm || ($urandom_range(99) >= 16);
        end
    end

    task automatic send_word(input logic [7:0] c, input logic fin);
        while (!calm && $urandom_range(99) < 16)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.char_in    <= c;
        in_ch.final_char <= fin;
        do
            @(posedge clk);
        while (!in_ch.ready);
        if (sb.note_input(c, fin))
            live_items++;
    endtask

    task automatic send_text_q();
        for (int i = 0; i < text_q.size(); i++)
            send_word(text_q[i], i == text_q.size() - 1);
        text_q.delete();
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            text_q.push_back(s[i]);
    endtask

    task automatic wait_for_drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // Mostly well-formed strings with random escapes, some noise and broken endings.
    task automatic build_random_string();
        string      esc_letters;
        string      hex_digits;
        int         ntok;
        int         n;
        int         ending;
        logic [7:0] b;
        esc_letters = "ntvbrf";
        hex_digits  = "0123456789abcdefABCDEF";
        text_q.delete();
        if ($urandom_range(99) < 12)
        begin
            n = $urandom_range(1, 6);
            repeat (n)
                text_q.push_back(8'($urandom_range(255)));
            return;
        end
        text_q.push_back(CH_QUOTE);
        ntok = $urandom_range(8);
        repeat (ntok)
        begin
            case ($urandom_range(9))
                0, 1, 2, 3:
                begin
                    b = 8'($urandom_range(255));
                    if (b == CH_BSL || b == CH_QUOTE)
                        b = CH_X;
                    text_q.push_back(b);
                end
                4:
                begin
                    text_q.push_back(CH_BSL);
                    text_q.push_back(esc_letters[$urandom_range(5)]);
                end
                5:
                begin
                    text_q.push_back(CH_BSL);
                    n = $urandom_range(1, 3);
                    repeat (n)
                        text_q.push_back(CH_0 + 8'($urandom_range(7)));
                end
                6:
                begin
                    text_q.push_back(CH_BSL);
                    text_q.push_back(CH_X);
                    n = $urandom_range(3);
                    repeat (n)
                        text_q.push_back(hex_digits[$urandom_range(21)]);
                end
                7:
                begin
                    text_q.push_back(CH_BSL);
                    text_q.push_back(8'($urandom_range(255)));
                end
                8:
                    text_q.push_back(CH_0 + 8'($urandom_range(9)));
                default:
                    text_q.push_back(($urandom_range(1) ? CH_LA : CH_UA)
                                     + 8'($urandom_range(6)));
            endcase
        end
        ending = $urandom_range(99);
        if (ending < 60)
            text_q.push_back(CH_QUOTE);
        else if (ending < 75)
        begin
            // unclosed: the last body byte carries the final flag
        end
        else if (ending < 85)
            text_q.push_back(CH_BSL);
        else
        begin
            text_q.push_back(CH_QUOTE);
            n = $urandom_range(1, 3);
            repeat (n)
                text_q.push_back(8'($urandom_range(255)));
        end
    endtask

    initial
    begin : stimulus
        int unsigned strings;
        rst_n            = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.char_in    = 8'h00;
        in_ch.final_char = 1'b0;
        calm             = 1'b0;
        stall_req        = 1'b0;
        live_items       = 0;
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;

        // missing opening quote, rest of the string dropped
        add_text("AB");
        send_text_q();
        // zero byte, byte extremes, escapes, octal wrap, text after closing quote
        add_text("\"");
        text_q.push_back(8'h00);
        text_q.push_back(8'hFF);
        add_text("\\n\\t\\777\"z");
        send_text_q();
        // hex with no digits cut short by a dangling backslash
        add_text("\"\\v\\b\\x\\");
        send_text_q();
        // three hex digits with wrap, unclosed string ending inside an octal escape
        add_text("\"\\r\\f\\xfFf\\41");
        send_text_q();
        // literal escape, short hex escape ended by a non-digit on the last byte
        add_text("\"\\q\\x4g");
        send_text_q();
        // lone opening quote as the whole string
        add_text("\"");
        send_text_q();

        live_items = 0;
        strings    = 0;
        while (live_items < RANDOM_ITEMS)
        begin
            calm = (strings >= 15 && strings < 30);
            if (strings == 35)
                stall_req = 1'b1;
            if (strings == 50)
                wait_for_drain();
            build_random_string();
            send_text_q();
            strings++;
        end

        wait_for_drain();
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
